// File: hw/rtl/usb_standard_request_handler_defines.svh
// Assertion macros for the standard request handler RTL.
// Included by usrh_back, which carries the concurrent checks; needs clk and rst_n in scope.
`ifndef USB_STANDARD_REQUEST_HANDLER_DEFINES_SVH
`define USB_STANDARD_REQUEST_HANDLER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define USRH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define USRH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define USRH_ASSERT_NOW(lbl, ante, cons, msg)
`define USRH_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/usrh_pkg.sv
// Types, codes and helper functions for the USB standard request handler.
// Used by the front decoder, the command queue, the back end and the top level.
`timescale 1ns / 1ps

package usrh_pkg;

    // Reply kinds carried on the result stream.
    typedef enum logic [1:0] {
        RESP_ACK     = 2'd0,
        RESP_DATA    = 2'd1,
        RESP_STALL   = 2'd2,
        RESP_FORWARD = 2'd3
    } resp_t;

    // Operations handed from the decoder to the back end.
    typedef enum logic [3:0] {
        OP_BUS_RESET,
        OP_FIXED,
        OP_EP_STATUS,
        OP_CLEAR_HALT,
        OP_SET_HALT,
        OP_SET_ADDRESS,
        OP_GET_CONFIG,
        OP_SET_CONFIG,
        OP_GET_INTERFACE,
        OP_SET_INTERFACE
    } op_t;

    // Standard request codes (bRequest).
    localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
    localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

    // bmRequestType values that select a get status recipient.
    localparam logic [7:0] RTYPE_DEVICE_IN   = 8'h80;
    localparam logic [7:0] RTYPE_ENDPOINT_IN = 8'h82;
    localparam logic [4:0] RECIPIENT_DEVICE  = 5'd0;

    // Feature selectors.
    localparam logic [7:0] FEAT_ENDPOINT_HALT  = 8'd0;
    localparam logic [7:0] FEAT_REMOTE_WAKEUP  = 8'd1;

    // Descriptor types (high byte of wValue).
    localparam logic [7:0] DESC_DEVICE    = 8'd1;
    localparam logic [7:0] DESC_CONFIG    = 8'd2;
    localparam logic [7:0] DESC_STRING    = 8'd3;
    localparam logic [7:0] DESC_QUALIFIER = 8'd6;
    localparam logic [7:0] STRING_COUNT   = 8'd4;

    // Descriptor identifiers reported with a data reply.
    localparam logic [2:0] DID_NONE      = 3'd0;
    localparam logic [2:0] DID_DEVICE    = 3'd1;
    localparam logic [2:0] DID_QUALIFIER = 3'd2;
    localparam logic [2:0] DID_CONFIG    = 3'd3;
    localparam logic [2:0] DID_STRING0   = 3'd4;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_DESC_LEN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUALIFIER_DESC_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIG_TOTAL_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LANG_STRING_LEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VENDOR_STRING_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRODUCT_STRING_LEN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SERIAL_STRING_LEN  = 3'd6;

    // Fixed reply lengths for inline replies.
    localparam logic [15:0] STATUS_LEN = 16'd2;
    localparam logic [15:0] ONE_BYTE_LEN = 16'd1;

    // Decoded command passed through the queue.
    typedef struct packed {
        op_t         op;
        resp_t       resp;
        logic [15:0] dlen;
        logic [7:0]  byte0;
        logic [2:0]  did;
        logic [3:0]  ep;
        logic [7:0]  value;
    } cmd_t;

    // One result word.
    typedef struct packed {
        resp_t       response;
        logic [15:0] data_length;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [2:0]  descriptor_id;
        logic [6:0]  device_address;
        logic        address_update;
        logic        endpoints_configure;
        logic [7:0]  configuration_value;
    } result_t;

    // Clip a reply length to what the host asked for.
    function automatic logic [15:0] clip_len(input logic [15:0] n, input logic [15:0] limit);
        return (n < limit) ? n : limit;
    endfunction

endpackage

// File: hw/rtl/usrh_front.sv
// Front end: holds the descriptor length registers and decodes each setup word.
// Depends on usrh_pkg; feeds decoded commands to usrh_fifo.
`timescale 1ns / 1ps

module usrh_front #(
    parameter int unsigned NUM_ENDPOINTS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [usrh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_data,
    input  logic                              mode,
    input  logic [7:0]                        request_type,
    input  logic [7:0]                        request_code,
    input  logic [7:0]                        value_low,
    input  logic [7:0]                        value_high,
    input  logic [15:0]                       index_word,
    input  logic [15:0]                       length_word,
    output usrh_pkg::cmd_t                    cmd
);

    localparam logic [4:0] EP_LIMIT = 5'(NUM_ENDPOINTS);

    logic [7:0]  device_len_reg;
    logic [7:0]  qualifier_len_reg;
    logic [15:0] config_len_reg;
    logic [7:0]  lang_len_reg;
    logic [7:0]  vendor_len_reg;
    logic [7:0]  product_len_reg;
    logic [7:0]  serial_len_reg;
    logic        ep_ok;
    logic [7:0]  string_len;
    logic [15:0] desc_len;
    logic [2:0]  desc_id;

    // Descriptor length registers, written by user only while idle; unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_len_reg    <= 8'd18;
            qualifier_len_reg <= 8'd10;
            config_len_reg    <= 16'd32;
            lang_len_reg      <= 8'd4;
            vendor_len_reg    <= 8'd0;
            product_len_reg   <= 8'd0;
            serial_len_reg    <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                usrh_pkg::REG_DEVICE_DESC_LEN:    device_len_reg    <= cfg_data[7:0];
                usrh_pkg::REG_QUALIFIER_DESC_LEN: qualifier_len_reg <= cfg_data[7:0];
                usrh_pkg::REG_CONFIG_TOTAL_LEN:   config_len_reg    <= cfg_data;
                usrh_pkg::REG_LANG_STRING_LEN:    lang_len_reg      <= cfg_data[7:0];
                usrh_pkg::REG_VENDOR_STRING_LEN:  vendor_len_reg    <= cfg_data[7:0];
                usrh_pkg::REG_PRODUCT_STRING_LEN: product_len_reg   <= cfg_data[7:0];
                usrh_pkg::REG_SERIAL_STRING_LEN:  serial_len_reg    <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Endpoint number range check on the low nibble of wIndex.
    assign ep_ok = {1'b0, index_word[3:0]} < EP_LIMIT;

    // String descriptor length by string index.
    always_comb
    begin
        case (value_low[1:0])
            2'd0:    string_len = lang_len_reg;
            2'd1:    string_len = vendor_len_reg;
            2'd2:    string_len = product_len_reg;
            default: string_len = serial_len_reg;
        endcase
    end

    // Descriptor selection; an unknown type leaves the id at none.
    always_comb
    begin
        desc_id  = usrh_pkg::DID_NONE;
        desc_len = 16'd0;
        case (value_high)
            usrh_pkg::DESC_DEVICE:
            begin
                desc_id  = usrh_pkg::DID_DEVICE;
                desc_len = {8'd0, device_len_reg};
            end
            usrh_pkg::DESC_QUALIFIER:
            begin
                desc_id  = usrh_pkg::DID_QUALIFIER;
                desc_len = {8'd0, qualifier_len_reg};
            end
            usrh_pkg::DESC_CONFIG:
            begin
                desc_id  = usrh_pkg::DID_CONFIG;
                desc_len = config_len_reg;
            end
            usrh_pkg::DESC_STRING:
            begin
                if (value_low < usrh_pkg::STRING_COUNT)
                begin
                    desc_id  = usrh_pkg::DID_STRING0 + {1'b0, value_low[1:0]};
                    desc_len = {8'd0, string_len};
                end
            end
            default:
            begin
            end
        endcase
    end

    // Request classification into a command for the back end.
    always_comb
    begin
        cmd.op    = usrh_pkg::OP_FIXED;
        cmd.resp  = usrh_pkg::RESP_ACK;
        cmd.dlen  = 16'd0;
        cmd.byte0 = 8'd0;
        cmd.did   = usrh_pkg::DID_NONE;
        cmd.ep    = index_word[3:0];
        cmd.value = value_low;
        if (mode)
        begin
            cmd.op = usrh_pkg::OP_BUS_RESET;
        end
        else if (request_type[6:5] != 2'd0)
        begin
            cmd.resp = usrh_pkg::RESP_FORWARD;
        end
        else
        begin
            case (request_code)
                usrh_pkg::REQ_GET_STATUS:
                begin
                    if (request_type == usrh_pkg::RTYPE_ENDPOINT_IN && !ep_ok)
                    begin
                        cmd.resp = usrh_pkg::RESP_STALL;
                    end
                    else
                    begin
                        cmd.resp = usrh_pkg::RESP_DATA;
                        cmd.dlen = usrh_pkg::clip_len(usrh_pkg::STATUS_LEN, length_word);
                        if (request_type == usrh_pkg::RTYPE_ENDPOINT_IN)
                        begin
                            cmd.op = usrh_pkg::OP_EP_STATUS;
                        end
                        else if (request_type == usrh_pkg::RTYPE_DEVICE_IN)
                        begin
                            // Self powered.
                            cmd.byte0 = 8'd1;
                        end
                    end
                end
                usrh_pkg::REQ_CLEAR_FEATURE, usrh_pkg::REQ_SET_FEATURE:
                begin
                    if (value_low == usrh_pkg::FEAT_REMOTE_WAKEUP)
                    begin
                        cmd.resp = usrh_pkg::RESP_ACK;
                    end
                    else if (value_low == usrh_pkg::FEAT_ENDPOINT_HALT && ep_ok)
                    begin
                        cmd.op = (request_code == usrh_pkg::REQ_CLEAR_FEATURE)
                               ? usrh_pkg::OP_CLEAR_HALT : usrh_pkg::OP_SET_HALT;
                    end
                    else
                    begin
                        cmd.resp = usrh_pkg::RESP_STALL;
                    end
                end
                usrh_pkg::REQ_SET_ADDRESS:
                begin
                    cmd.op = usrh_pkg::OP_SET_ADDRESS;
                end
                usrh_pkg::REQ_GET_DESCRIPTOR:
                begin
                    if (desc_id == usrh_pkg::DID_NONE)
                    begin
                        cmd.resp = usrh_pkg::RESP_STALL;
                    end
                    else
                    begin
                        cmd.resp = usrh_pkg::RESP_DATA;
                        cmd.did  = desc_id;
                        cmd.dlen = usrh_pkg::clip_len(desc_len, length_word);
                    end
                end
                usrh_pkg::REQ_GET_CONFIGURATION:
                begin
                    cmd.op   = usrh_pkg::OP_GET_CONFIG;
                    cmd.resp = usrh_pkg::RESP_DATA;
                    cmd.dlen = usrh_pkg::clip_len(usrh_pkg::ONE_BYTE_LEN, length_word);
                end
                usrh_pkg::REQ_SET_CONFIGURATION:
                begin
                    if (request_type[4:0] == usrh_pkg::RECIPIENT_DEVICE)
                    begin
                        cmd.op = usrh_pkg::OP_SET_CONFIG;
                    end
                    else
                    begin
                        cmd.resp = usrh_pkg::RESP_STALL;
                    end
                end
                usrh_pkg::REQ_GET_INTERFACE:
                begin
                    cmd.op   = usrh_pkg::OP_GET_INTERFACE;
                    cmd.resp = usrh_pkg::RESP_DATA;
                    cmd.dlen = usrh_pkg::clip_len(usrh_pkg::ONE_BYTE_LEN, length_word);
                end
                usrh_pkg::REQ_SET_INTERFACE:
                begin
                    cmd.op = usrh_pkg::OP_SET_INTERFACE;
                end
                default:
                begin
                    cmd.resp = usrh_pkg::RESP_STALL;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/usrh_fifo.sv
// Two-entry command queue between the decoder and the back end.
// Depends on usrh_pkg for the command type.
`timescale 1ns / 1ps

module usrh_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  usrh_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output usrh_pkg::cmd_t pop_data
);

    usrh_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    logic           pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/usrh_back.sv
// Back end: device state (address, configuration, interface, halt bits) and result register.
// Depends on usrh_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "usb_standard_request_handler_defines.svh"

module usrh_back #(
    parameter int unsigned NUM_ENDPOINTS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  usrh_pkg::cmd_t    cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output usrh_pkg::result_t out_data
);

    localparam int unsigned EP_IDX_W = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;

    logic [6:0]               address_reg;
    logic [6:0]               address_next;
    logic [7:0]               config_reg;
    logic [7:0]               config_next;
    logic [7:0]               interface_reg;
    logic [7:0]               interface_next;
    logic [NUM_ENDPOINTS-1:0] halt_reg;
    logic [NUM_ENDPOINTS-1:0] halt_next;
    logic                     valid_reg;
    logic                     valid_next;
    usrh_pkg::result_t        result_reg;
    usrh_pkg::result_t        result_next;
    logic [EP_IDX_W-1:0]      ep_idx;
    logic                     pop;

    assign cmd_ready = !valid_reg || out_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign ep_idx    = cmd.ep[EP_IDX_W-1:0];
    assign out_valid = valid_reg;
    assign out_data  = result_reg;

    // Execute one command against the device state.
    always_comb
    begin
        address_next   = address_reg;
        config_next    = config_reg;
        interface_next = interface_reg;
        halt_next      = halt_reg;
        result_next.response            = cmd.resp;
        result_next.data_length         = cmd.dlen;
        result_next.first_byte          = cmd.byte0;
        result_next.second_byte         = 8'd0;
        result_next.descriptor_id       = cmd.did;
        result_next.address_update      = 1'b0;
        result_next.endpoints_configure = 1'b0;
        case (cmd.op)
            usrh_pkg::OP_BUS_RESET:
            begin
                address_next   = 7'd0;
                config_next    = 8'd0;
                interface_next = 8'd0;
                halt_next      = '0;
            end
            usrh_pkg::OP_EP_STATUS:
            begin
                result_next.first_byte = {7'd0, halt_reg[ep_idx]};
            end
            usrh_pkg::OP_CLEAR_HALT:
            begin
                halt_next[ep_idx] = 1'b0;
            end
            usrh_pkg::OP_SET_HALT:
            begin
                halt_next[ep_idx] = 1'b1;
            end
            usrh_pkg::OP_SET_ADDRESS:
            begin
                address_next               = cmd.value[6:0];
                result_next.address_update = 1'b1;
            end
            usrh_pkg::OP_GET_CONFIG:
            begin
                result_next.first_byte = config_reg;
            end
            usrh_pkg::OP_SET_CONFIG:
            begin
                config_next                     = cmd.value;
                result_next.endpoints_configure = 1'b1;
            end
            usrh_pkg::OP_GET_INTERFACE:
            begin
                result_next.first_byte = interface_reg;
            end
            usrh_pkg::OP_SET_INTERFACE:
            begin
                interface_next = cmd.value;
            end
            default:
            begin
            end
        endcase
        result_next.device_address      = address_next;
        result_next.configuration_value = config_next;
    end

    // Result register valid flag: loads on a pop, clears when taken.
    always_comb
    begin
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Device state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg   <= 7'd0;
            config_reg    <= 8'd0;
            interface_reg <= 8'd0;
            halt_reg      <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                address_reg   <= address_next;
                config_reg    <= config_next;
                interface_reg <= interface_next;
                halt_reg      <= halt_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

    // A held result must not be overwritten by a new command.
    `USRH_ASSERT_NOW(a_no_overwrite, valid_reg && !out_ready, !pop, "result overwritten while stalled")
    // A bus reset leaves the device unaddressed and unconfigured.
    `USRH_ASSERT_NEXT(a_bus_reset, pop && cmd.op == usrh_pkg::OP_BUS_RESET, address_reg == 7'd0 && config_reg == 8'd0 && halt_reg == '0, "bus reset did not clear state")
    // A set address shows the new address with the update flag.
    `USRH_ASSERT_NEXT(a_set_address, pop && cmd.op == usrh_pkg::OP_SET_ADDRESS, valid_reg && result_reg.address_update && result_reg.device_address == $past(cmd.value[6:0]), "set address result wrong")
    // The reported address always tracks the state register.
    `USRH_ASSERT_NOW(a_addr_tracks, valid_reg, result_reg.device_address == address_reg || pop, "result address differs from state")

endmodule

// File: hw/rtl/usb_standard_request_handler.sv
// USB standard (chapter 9) request handler - top level.
// Channels: s_* carries one decoded setup packet or bus reset event per word;
//   s_tuser is the mode bit (0 setup packet, 1 bus reset).
// m_* carries exactly one result word for every accepted input word, in order;
//   m_tuser is the response code (ack, data, stall, forward to class).
// cfg_wr_en/cfg_index/cfg_data write the descriptor length registers; write them
//   only while no request is in flight.
// Each word goes through a queue entry and then the result register to reach m_*.
// Throughput: one word per cycle while m_tready stays high; the decoder, a two-entry
//   command queue and the back end state register each take one word per cycle.
// When the receiver holds m_tready low the result register holds its word, the
//   queue fills, and s_tready drops once both queue entries are occupied.
// Reset clears the device address, configuration, interface and halt bits, empties
//   the queue and the result register, and loads the default descriptor lengths.
// Depends on usrh_pkg, usrh_front, usrh_fifo and usrh_back.
`timescale 1ns / 1ps

module usb_standard_request_handler #(
    parameter int unsigned NUM_ENDPOINTS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [usrh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // request_type[7:0], request_code[15:8], value_low[23:16], value_high[31:24],
    // index_word[47:32], length_word[63:48]
    input  logic [63:0]                    s_tdata,
    // mode[0]
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // data_length[15:0], first_byte[23:16], second_byte[31:24], descriptor_id[34:32],
    // device_address[41:35], address_update[42], endpoints_configure[43],
    // configuration_value[51:44], zero fill[55:52]
    output logic [55:0]                    m_tdata,
    // response[1:0]
    output logic [1:0]                     m_tuser
);

    usrh_pkg::cmd_t    front_cmd;
    usrh_pkg::cmd_t    queue_cmd;
    logic              queue_valid;
    logic              queue_ready;
    usrh_pkg::result_t result;

    // Decode the incoming word.
    usrh_front #(
        .NUM_ENDPOINTS (NUM_ENDPOINTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mode         (s_tuser[0]),
        .request_type (s_tdata[7:0]),
        .request_code (s_tdata[15:8]),
        .value_low    (s_tdata[23:16]),
        .value_high   (s_tdata[31:24]),
        .index_word   (s_tdata[47:32]),
        .length_word  (s_tdata[63:48]),
        .cmd          (front_cmd)
    );

    // Queue decoded commands.
    usrh_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_data  (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_cmd)
    );

    // Execute against device state and register the result.
    usrh_back #(
        .NUM_ENDPOINTS (NUM_ENDPOINTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    // Pack the result word.
    assign m_tuser = result.response;
    assign m_tdata = {4'd0,
                      result.configuration_value,
                      result.endpoints_configure,
                      result.address_update,
                      result.device_address,
                      result.descriptor_id,
                      result.second_byte,
                      result.first_byte,
                      result.data_length};

endmodule

// File: sim/tb_usb_standard_request_handler.sv
// Self-checking testbench for the USB standard request handler.
// Drives setup words and bus resets on s_*, predicts every reply and checks m_*.
// Depends on usrh_pkg and the usb_standard_request_handler RTL.
`timescale 1ns / 1ps

module tb_usb_standard_request_handler;

    localparam int unsigned NUM_EP       = 4;
    localparam int unsigned EP_W         = $clog2(NUM_EP);
    localparam int unsigned STALL_LIMIT  = 500;
    localparam int unsigned PHASE_WORDS  = 380;

    // Request types and codes that the package does not name.
    localparam logic [7:0] RT_DEVICE_OUT      = 8'h00;
    localparam logic [7:0] RT_INTERFACE_OUT   = 8'h01;
    localparam logic [7:0] RT_ENDPOINT_OUT    = 8'h02;
    localparam logic [7:0] RT_INTERFACE_IN    = 8'h81;
    localparam logic [7:0] RT_CLASS_OUT       = 8'h21;
    localparam logic [7:0] RT_VENDOR_IN       = 8'hC0;
    localparam logic [7:0] REQ_SET_DESCRIPTOR = 8'd7;
    localparam logic [7:0] REQ_UNKNOWN        = 8'hFF;
    localparam logic       MODE_SETUP         = 1'b0;
    localparam logic       MODE_BUS_RESET     = 1'b1;
    localparam logic [2:0] REG_NONE           = 3'd7;

    typedef struct {
        logic        mode;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [7:0]  value_low;
        logic [7:0]  value_high;
        logic [15:0] index_word;
        logic [15:0] length_word;
    } setup_word_t;

    typedef enum logic [1:0] {
        STEP_SETUP,
        STEP_REG_WRITE,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t  kind;
        setup_word_t setup;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
    } step_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    // Stimulus queue, expected replies and the mirrored device state.
    step_t             pending_steps[$];
    usrh_pkg::result_t expected_replies[$];
    setup_word_t       offered_setup;
    logic [6:0]        dev_address;
    logic [7:0]        active_config;
    logic [7:0]        alt_setting;
    logic [NUM_EP-1:0] halt_mask;
    logic [15:0]       desc_len [0:6];
    int                mismatch_count = 0;
    int                send_gap = 0;
    int                send_calm = 0;
    int                recv_wait = 0;
    int                recv_calm = 0;
    int                quiet_cycles = 0;

    usb_standard_request_handler #(
        .NUM_ENDPOINTS(NUM_EP)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [15:0] shorter_of(input logic [15:0] a, input logic [15:0] b);
        return (a < b) ? a : b;
    endfunction

    // Wait before the next word: mostly a short random gap, with runs of back-to-back words.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // Work out the reply to one word and advance the mirrored device state.
    function automatic usrh_pkg::result_t predict_reply(input setup_word_t w);
        usrh_pkg::result_t r;
        logic [3:0]        ep;
        logic [EP_W-1:0]   ep_sel;
        logic              ep_ok;
        logic [15:0]       n;
        r = '0;
        r.response = usrh_pkg::RESP_ACK;
        ep = w.index_word[3:0];
        ep_sel = ep[EP_W-1:0];
        ep_ok = (ep < NUM_EP);
        n = '0;
        if (w.mode == MODE_BUS_RESET)
        begin
            dev_address = '0;
            active_config = '0;
            alt_setting = '0;
            halt_mask = '0;
        end
        else if (w.request_type[6:5] != 2'b00)
        begin
            r.response = usrh_pkg::RESP_FORWARD;
        end
        else
        begin
            case (w.request_code)
                usrh_pkg::REQ_GET_STATUS:
                begin
                    if (w.request_type == usrh_pkg::RTYPE_ENDPOINT_IN && !ep_ok)
                        r.response = usrh_pkg::RESP_STALL;
                    else
                    begin
                        if (w.request_type == usrh_pkg::RTYPE_DEVICE_IN)
                            r.first_byte = 8'd1;
                        else if (w.request_type == usrh_pkg::RTYPE_ENDPOINT_IN)
                            r.first_byte = {7'd0, halt_mask[ep_sel]};
                        r.response = usrh_pkg::RESP_DATA;
                        r.data_length = shorter_of(16'd2, w.length_word);
                    end
                end
                usrh_pkg::REQ_CLEAR_FEATURE, usrh_pkg::REQ_SET_FEATURE:
                begin
                    if (w.value_low == usrh_pkg::FEAT_REMOTE_WAKEUP)
                        r.response = usrh_pkg::RESP_ACK;
                    else if (w.value_low == usrh_pkg::FEAT_ENDPOINT_HALT && ep_ok)
                        halt_mask[ep_sel] = (w.request_code == usrh_pkg::REQ_SET_FEATURE);
                    else
                        r.response = usrh_pkg::RESP_STALL;
                end
                usrh_pkg::REQ_SET_ADDRESS:
                begin
                    dev_address = w.value_low[6:0];
                    r.address_update = 1'b1;
                end
                usrh_pkg::REQ_GET_DESCRIPTOR:
                begin
                    if (w.value_high == usrh_pkg::DESC_DEVICE)
                    begin
                        r.descriptor_id = usrh_pkg::DID_DEVICE;
                        n = desc_len[usrh_pkg::REG_DEVICE_DESC_LEN];
                    end
                    else if (w.value_high == usrh_pkg::DESC_QUALIFIER)
                    begin
                        r.descriptor_id = usrh_pkg::DID_QUALIFIER;
                        n = desc_len[usrh_pkg::REG_QUALIFIER_DESC_LEN];
                    end
                    else if (w.value_high == usrh_pkg::DESC_CONFIG)
                    begin
                        r.descriptor_id = usrh_pkg::DID_CONFIG;
                        n = desc_len[usrh_pkg::REG_CONFIG_TOTAL_LEN];
                    end
                    else if (w.value_high == usrh_pkg::DESC_STRING
                             && w.value_low < usrh_pkg::STRING_COUNT)
                    begin
                        r.descriptor_id = usrh_pkg::DID_STRING0 + w.value_low[2:0];
                        n = desc_len[usrh_pkg::REG_LANG_STRING_LEN + w.value_low[2:0]];
                    end
                    if (r.descriptor_id == usrh_pkg::DID_NONE)
                        r.response = usrh_pkg::RESP_STALL;
                    else
                    begin
                        r.response = usrh_pkg::RESP_DATA;
                        r.data_length = shorter_of(n, w.length_word);
                    end
                end
                usrh_pkg::REQ_GET_CONFIGURATION:
                begin
                    r.response = usrh_pkg::RESP_DATA;
                    r.first_byte = active_config;
                    r.data_length = shorter_of(16'd1, w.length_word);
                end
                usrh_pkg::REQ_SET_CONFIGURATION:
                begin
                    if (w.request_type[4:0] == usrh_pkg::RECIPIENT_DEVICE)
                    begin
                        active_config = w.value_low;
                        r.endpoints_configure = 1'b1;
                    end
                    else
                        r.response = usrh_pkg::RESP_STALL;
                end
                usrh_pkg::REQ_GET_INTERFACE:
                begin
                    r.response = usrh_pkg::RESP_DATA;
                    r.first_byte = alt_setting;
                    r.data_length = shorter_of(16'd1, w.length_word);
                end
                usrh_pkg::REQ_SET_INTERFACE:
                begin
                    alt_setting = w.value_low;
                end
                default:
                begin
                    r.response = usrh_pkg::RESP_STALL;
                end
            endcase
        end
        r.device_address = dev_address;
        r.configuration_value = active_config;
        return r;
    endfunction

    // Random word: mostly well-formed standard requests, some forwards, resets and noise.
    function automatic setup_word_t random_request();
        setup_word_t w;
        int          pick;
        w.mode = MODE_SETUP;
        w.request_type = 8'($urandom);
        w.request_code = 8'($urandom);
        w.value_low = 8'($urandom);
        w.value_high = 8'($urandom);
        w.index_word = 16'($urandom);
        w.length_word = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4)
            w.mode = MODE_BUS_RESET;
        else if (pick < 12)
            w.request_type[6:5] = 2'($urandom_range(1, 3));
        else if (pick >= 16)
        begin
            w.request_type[6:5] = 2'b00;
            if ($urandom_range(0, 3) != 0)
                w.request_type[4:0] = 5'($urandom_range(0, 3));
            if ($urandom_range(0, 3) != 0)
                w.index_word[3:0] = 4'($urandom_range(0, NUM_EP));
            if ($urandom_range(0, 1) != 0)
                w.index_word[15:4] = '0;
            case ($urandom_range(0, 5))
                0: w.length_word = '0;
                1: w.length_word = 16'($urandom_range(1, 3));
                2: w.length_word = 16'($urandom_range(0, 64));
                3: w.length_word = 16'($urandom_range(200, 300));
                4: w.length_word = 16'hFFFF;
                default: ;
            endcase
            case ($urandom_range(0, 10))
                0:
                begin
                    w.request_code = usrh_pkg::REQ_GET_STATUS;
                    w.request_type[7] = 1'b1;
                end
                1: w.request_code = usrh_pkg::REQ_CLEAR_FEATURE;
                2: w.request_code = usrh_pkg::REQ_SET_FEATURE;
                3: w.request_code = usrh_pkg::REQ_SET_ADDRESS;
                4: w.request_code = usrh_pkg::REQ_GET_DESCRIPTOR;
                5: w.request_code = REQ_SET_DESCRIPTOR;
                6: w.request_code = usrh_pkg::REQ_GET_CONFIGURATION;
                7: w.request_code = usrh_pkg::REQ_SET_CONFIGURATION;
                8: w.request_code = usrh_pkg::REQ_GET_INTERFACE;
                9: w.request_code = usrh_pkg::REQ_SET_INTERFACE;
                default: ;
            endcase
            if (w.request_code == usrh_pkg::REQ_CLEAR_FEATURE
                || w.request_code == usrh_pkg::REQ_SET_FEATURE)
            begin
                if ($urandom_range(0, 7) != 0)
                    w.value_low = 8'($urandom_range(0, 2));
            end
            if (w.request_code == usrh_pkg::REQ_GET_DESCRIPTOR && $urandom_range(0, 7) != 0)
            begin
                case ($urandom_range(0, 3))
                    0: w.value_high = usrh_pkg::DESC_DEVICE;
                    1: w.value_high = usrh_pkg::DESC_QUALIFIER;
                    2: w.value_high = usrh_pkg::DESC_CONFIG;
                    default: w.value_high = usrh_pkg::DESC_STRING;
                endcase
                if ($urandom_range(0, 3) != 0)
                    w.value_low = 8'($urandom_range(0, 4));
            end
            if (w.request_code == usrh_pkg::REQ_SET_CONFIGURATION && $urandom_range(0, 3) != 0)
                w.request_type[4:0] = usrh_pkg::RECIPIENT_DEVICE;
        end
        return w;
    endfunction

    task automatic add_setup(input setup_word_t w);
        step_t s;
        s.kind = STEP_SETUP;
        s.setup = w;
        s.reg_index = '0;
        s.reg_value = '0;
        pending_steps.push_back(s);
    endtask

    task automatic add_request(input logic mode, input logic [7:0] rtype, input logic [7:0] code,
                               input logic [7:0] vlo, input logic [7:0] vhi,
                               input logic [15:0] idx, input logic [15:0] len);
        setup_word_t w;
        w.mode = mode;
        w.request_type = rtype;
        w.request_code = code;
        w.value_low = vlo;
        w.value_high = vhi;
        w.index_word = idx;
        w.length_word = len;
        add_setup(w);
    endtask

    task automatic add_reg_write(input logic [2:0] idx, input logic [15:0] val);
        step_t s;
        s.kind = STEP_REG_WRITE;
        s.setup = '{default: '0};
        s.reg_index = idx;
        s.reg_value = val;
        pending_steps.push_back(s);
    endtask

    task automatic add_drain();
        step_t s;
        s.kind = STEP_DRAIN;
        s.setup = '{default: '0};
        s.reg_index = '0;
        s.reg_value = '0;
        pending_steps.push_back(s);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input longint got, input longint want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // Driver: offers queued words, writes registers only once every reply has come back.
    always @(posedge clk or negedge rst_n)
    begin
        logic  vld_next;
        logic  wr_next;
        step_t head;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            cfg_wr_en <= 1'b0;
            send_gap = 0;
            dev_address = '0;
            active_config = '0;
            alt_setting = '0;
            halt_mask = '0;
            desc_len[usrh_pkg::REG_DEVICE_DESC_LEN] = 16'd18;
            desc_len[usrh_pkg::REG_QUALIFIER_DESC_LEN] = 16'd10;
            desc_len[usrh_pkg::REG_CONFIG_TOTAL_LEN] = 16'd32;
            desc_len[usrh_pkg::REG_LANG_STRING_LEN] = 16'd4;
            desc_len[usrh_pkg::REG_VENDOR_STRING_LEN] = 16'd0;
            desc_len[usrh_pkg::REG_PRODUCT_STRING_LEN] = 16'd0;
            desc_len[usrh_pkg::REG_SERIAL_STRING_LEN] = 16'd0;
        end
        else
        begin
            vld_next = s_tvalid;
            wr_next = 1'b0;
            if (s_tvalid && s_tready)
            begin
                expected_replies.push_back(predict_reply(offered_setup));
                vld_next = 1'b0;
            end
            if (!vld_next && pending_steps.size() > 0)
            begin
                head = pending_steps[0];
                case (head.kind)
                    STEP_SETUP:
                    begin
                        if (send_gap > 0)
                            send_gap--;
                        else
                        begin
                            offered_setup = head.setup;
                            s_tdata <= {head.setup.length_word, head.setup.index_word,
                                        head.setup.value_high, head.setup.value_low,
                                        head.setup.request_code, head.setup.request_type};
                            s_tuser <= head.setup.mode;
                            vld_next = 1'b1;
                            send_gap = draw_wait(send_calm);
                            void'(pending_steps.pop_front());
                        end
                    end
                    STEP_REG_WRITE:
                    begin
                        if (expected_replies.size() == 0)
                        begin
                            cfg_index <= head.reg_index;
                            cfg_data <= head.reg_value;
                            wr_next = 1'b1;
                            if (head.reg_index == usrh_pkg::REG_CONFIG_TOTAL_LEN)
                                desc_len[head.reg_index] = head.reg_value;
                            else if (head.reg_index != REG_NONE)
                                desc_len[head.reg_index] = {8'd0, head.reg_value[7:0]};
                            void'(pending_steps.pop_front());
                        end
                    end
                    default:
                    begin
                        if (expected_replies.size() == 0)
                            void'(pending_steps.pop_front());
                    end
                endcase
            end
            s_tvalid <= vld_next;
            cfg_wr_en <= wr_next;
        end
    end

    // Monitor: stalls the result side at random and checks each word against the oldest reply.
    always @(posedge clk or negedge rst_n)
    begin
        usrh_pkg::result_t want;
        logic              rdy_next;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            rdy_next = m_tready;
            if (m_tvalid && m_tready)
            begin
                if (expected_replies.size() == 0)
                    report_mismatch("result word with nothing expected", {m_tdata, m_tuser}, 0);
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("response", m_tuser, want.response);
                    check_field("data_length", m_tdata[15:0], want.data_length);
                    check_field("first_byte", m_tdata[23:16], want.first_byte);
                    check_field("second_byte", m_tdata[31:24], want.second_byte);
                    check_field("descriptor_id", m_tdata[34:32], want.descriptor_id);
                    check_field("device_address", m_tdata[41:35], want.device_address);
                    check_field("address_update", m_tdata[42], want.address_update);
                    check_field("endpoints_configure", m_tdata[43], want.endpoints_configure);
                    check_field("configuration_value", m_tdata[51:44],
                                want.configuration_value);
                end
                rdy_next = 1'b0;
                recv_wait = draw_wait(recv_calm);
            end
            if (!rdy_next)
            begin
                if (recv_wait > 0)
                    recv_wait--;
                else
                    rdy_next = 1'b1;
            end
            m_tready <= rdy_next;
        end
    end

    // Watchdog: ends the run when no word or register write moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_usb_standard_request_handler NOT OK");
                $finish;
            end
        end
    end

    // Stimulus, then the wait for the last reply and the verdict.
    initial
    begin
        int          phase;
        int          r;
        int          k;
        logic [15:0] val;

        // Directed words at the reset lengths.
        add_request(MODE_SETUP, usrh_pkg::RTYPE_DEVICE_IN, usrh_pkg::REQ_GET_STATUS,
                    8'h00, 8'h00, 16'h0000, 16'hFFFF);
        add_request(MODE_SETUP, RT_INTERFACE_IN, usrh_pkg::REQ_GET_STATUS,
                    8'hFF, 8'hFF, 16'h0000, 16'h0001);
        add_request(MODE_SETUP, RT_ENDPOINT_OUT, usrh_pkg::REQ_SET_FEATURE,
                    usrh_pkg::FEAT_ENDPOINT_HALT, 8'h00, 16'h0083, 16'h0000);
        add_request(MODE_SETUP, usrh_pkg::RTYPE_ENDPOINT_IN, usrh_pkg::REQ_GET_STATUS,
                    8'h00, 8'h00, 16'hFFF3, 16'h0000);
        add_request(MODE_SETUP, usrh_pkg::RTYPE_ENDPOINT_IN, usrh_pkg::REQ_GET_STATUS,
                    8'h00, 8'h00, 16'h0004, 16'h0002);
        add_request(MODE_SETUP, RT_ENDPOINT_OUT, usrh_pkg::REQ_SET_FEATURE,
                    usrh_pkg::FEAT_ENDPOINT_HALT, 8'h00, 16'h000F, 16'h0000);
        add_request(MODE_SETUP, RT_ENDPOINT_OUT, usrh_pkg::REQ_CLEAR_FEATURE,
                    usrh_pkg::FEAT_ENDPOINT_HALT, 8'h00, 16'h0003, 16'h0000);
        add_request(MODE_SETUP, RT_DEVICE_OUT, usrh_pkg::REQ_SET_FEATURE,
                    usrh_pkg::FEAT_REMOTE_WAKEUP, 8'h00, 16'hFFFF, 16'h0000);
        add_request(MODE_SETUP, RT_DEVICE_OUT, usrh_pkg::REQ_CLEAR_FEATURE,
                    8'hFF, 8'h00, 16'h0000, 16'h0000);
        add_request(MODE_SETUP, RT_DEVICE_OUT, usrh_pkg::REQ_SET_ADDRESS,
                    8'hFF, 8'h00, 16'h0000, 16'h0000);
        add_request(MODE_SETUP, usrh_pkg::RTYPE_DEVICE_IN, usrh_pkg::REQ_GET_DESCRIPTOR,
                    8'h00, usrh_pkg::DESC_DEVICE, 16'h0000, 16'hFFFF);
        add_request(MODE_SETUP, usrh_pkg::RTYPE_DEVICE_IN, usrh_pkg::REQ_GET_DESCRIPTOR,
                    8'h00, usrh_pkg::DESC_QUALIFIER, 16'h0000, 16'h0005);
        add_request(MODE_SETUP, usrh_pkg::RTYPE_DEVICE_IN, usrh_pkg::REQ_GET_DESCRIPTOR,
                    8'h00, usrh_pkg::DESC_CONFIG, 16'h0000, 16'hFFFF);
        add_request(MODE_SETUP, usrh_pkg::RTYPE_DEVICE_IN, usrh_pkg::REQ_GET_DESCRIPTOR,
                    8'h00, usrh_pkg::DESC_STRING, 16'h0409, 16'h00FF);
        add_request(MODE_SETUP, usrh_pkg::RTYPE_DEVICE_IN, usrh_pkg::REQ_GET_DESCRIPTOR,
                    8'h03, usrh_pkg::DESC_STRING, 16'h0409, 16'h00FF);
        add_request(MODE_SETUP, usrh_pkg::RTYPE_DEVICE_IN, usrh_pkg::REQ_GET_DESCRIPTOR,
                    8'h04, usrh_pkg::DESC_STRING, 16'h0409, 16'h00FF);
        add_request(MODE_SETUP, usrh_pkg::RTYPE_DEVICE_IN, usrh_pkg::REQ_GET_DESCRIPTOR,
                    8'h00, 8'hFF, 16'h0000, 16'hFFFF);
        add_request(MODE_SETUP, RT_DEVICE_OUT, REQ_SET_DESCRIPTOR,
                    8'h00, usrh_pkg::DESC_DEVICE, 16'h0000, 16'h0012);
        add_request(MODE_SETUP, RT_DEVICE_OUT, usrh_pkg::REQ_SET_CONFIGURATION,
                    8'h01, 8'h00, 16'h0000, 16'h0000);
        add_request(MODE_SETUP, RT_INTERFACE_OUT, usrh_pkg::REQ_SET_CONFIGURATION,
                    8'h02, 8'h00, 16'h0000, 16'h0000);
        add_request(MODE_SETUP, usrh_pkg::RTYPE_DEVICE_IN, usrh_pkg::REQ_GET_CONFIGURATION,
                    8'h00, 8'h00, 16'h0000, 16'h0000);
        add_request(MODE_SETUP, RT_INTERFACE_OUT, usrh_pkg::REQ_SET_INTERFACE,
                    8'hAB, 8'h00, 16'h0000, 16'h0000);
        add_request(MODE_SETUP, RT_INTERFACE_IN, usrh_pkg::REQ_GET_INTERFACE,
                    8'h00, 8'h00, 16'h0000, 16'hFFFF);
        add_request(MODE_SETUP, RT_CLASS_OUT, usrh_pkg::REQ_SET_ADDRESS,
                    8'h11, 8'h00, 16'h0000, 16'h0000);
        add_request(MODE_SETUP, RT_VENDOR_IN, usrh_pkg::REQ_GET_STATUS,
                    8'h00, 8'h00, 16'h0000, 16'h0002);
        add_request(MODE_SETUP, RT_DEVICE_OUT, REQ_UNKNOWN, 8'h00, 8'h00, 16'h0000, 16'h0000);
        add_request(MODE_BUS_RESET, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        add_request(MODE_SETUP, usrh_pkg::RTYPE_DEVICE_IN, usrh_pkg::REQ_GET_CONFIGURATION,
                    8'h00, 8'h00, 16'h0000, 16'h0001);

        // Random phases: all lengths zero (upper byte set to check masking), all at
        // maximum, small lengths near typical wLength values, then fully random.
        for (phase = 0; phase < 5; phase++)
        begin
            for (r = 0; r < 7; r++)
            begin
                case (phase)
                    0: val = (3'(r) == usrh_pkg::REG_CONFIG_TOTAL_LEN) ? 16'h0000 : 16'hFF00;
                    1: val = 16'hFFFF;
                    2: val = 16'($urandom_range(0, 40));
                    default: val = 16'($urandom);
                endcase
                add_reg_write(3'(r), val);
            end
            if (phase == 4)
                add_reg_write(REG_NONE, 16'($urandom));
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                // Hold off once per phase until every reply is back.
                if (k == PHASE_WORDS / 2)
                    add_drain();
                add_setup(random_request());
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_steps.size() > 0 || s_tvalid || expected_replies.size() > 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_usb_standard_request_handler OK");
        else
            $display("tb_usb_standard_request_handler NOT OK");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/usrh_pkg.sv
hw/rtl/usrh_front.sv
hw/rtl/usrh_fifo.sv
hw/rtl/usrh_back.sv
hw/rtl/usb_standard_request_handler.sv
sim/tb_usb_standard_request_handler.sv
